>>> hdl/vvps_pkg.sv
// ============================================================================
// vvps_pkg
// Shared types, constants and helpers for the velocity Verlet step pipeline.
// ============================================================================
package vvps_pkg;

  // Pipeline depth and stage positions
  localparam int NSTG     = 7;
  localparam int ST_IN    = 0;  // input register
  localparam int ST_MUL   = 1;  // force*imass, vel*dt, alast*dt^2/2
  localparam int ST_APOS  = 2;  // new acceleration and new position
  localparam int ST_ASUM  = 3;  // (alast + anew) * dt
  localparam int ST_VSUM  = 4;  // vel + rounded increment
  localparam int ST_DAMP  = 5;  // times frame damping
  localparam int ST_OUT   = 6;  // output register

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DAMPING = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY       = 8'd2;

  // Register widths and reset values
  localparam int TS_W   = 16;
  localparam int DAMP_W = 17;
  localparam int GRAV_W = 31;
  localparam logic [TS_W-1:0]   TIME_STEP_RST = 16'd1092;
  localparam logic [DAMP_W-1:0] DAMPING_RST   = 17'd65525;
  localparam logic [GRAV_W-1:0] GRAVITY_RST   = 31'd642253;
  // dt*dt/2 in Q0.32 for the reset time step
  localparam logic [2*TS_W-2:0] HDT2_RST =
    (2*TS_W-1)'((32'(TIME_STEP_RST) * 32'(TIME_STEP_RST)) >> 1);

  // Axis code that receives gravity
  localparam logic [1:0] AXIS_Y = 2'd1;

  // Stream widths
  localparam int S_TDATA_W = 160;
  localparam int M_TDATA_W = 96;

  // Per-stage load strobes
  typedef struct packed {
    logic [NSTG-1:0] load;
  } pipe_ctl_t;

  // One input item
  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] last_accel;
    logic signed [31:0] force_req;
    logic signed [31:0] inverse_mass;
  } item_t;

  // Handoff from acceleration/position half to velocity half
  typedef struct packed {
    logic               skip;
    logic               clip;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] last_accel;
    logic signed [31:0] new_accel;
    logic signed [31:0] new_position;
  } ap_item_t;

  // One result item
  typedef struct packed {
    logic        skipped;
    logic        saturated;
    logic [31:0] new_position;
    logic [31:0] new_velocity;
    logic [31:0] new_accel;
  } res_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } sat_t;

  // Clip a wide signed value to 32-bit signed
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[31:0];
    if (v > 64'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'h8000_0000;
    end
    return r;
  endfunction

endpackage

>>> hdl/vvps_ctrl.sv
// ============================================================================
// vvps_ctrl
// Valid bits and per-stage ready chain for the step pipeline.
// ============================================================================
module vvps_ctrl import vvps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG-1:0] vin;
  logic [NSTG:0]   rdy;

  // A stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vin[0] = in_valid_i;
    for (int k = 1; k < NSTG; k++) begin
      vin[k] = vld_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      vld_d[k]      = rdy[k] ? vin[k] : vld_q[k];
      ctl_o.load[k] = rdy[k] && vin[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

endmodule

>>> hdl/vvps_accel_pos.sv
// ============================================================================
// vvps_accel_pos
// Multiply stage and new acceleration / new position stage.
// ============================================================================
module vvps_accel_pos import vvps_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pipe_ctl_t         ctl_i,
  input  item_t             item_i,
  input  logic [TS_W-1:0]   time_step_i,
  input  logic [GRAV_W-1:0] gravity_i,
  output ap_item_t          ap_o
);

  localparam logic signed [63:0] FM_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // dt*dt/2, tracks the time step register
  logic [2*TS_W-2:0] hdt2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdt2_q <= HDT2_RST;
    end else begin
      hdt2_q <= (2*TS_W-1)'((32'(time_step_i) * 32'(time_step_i)) >> 1);
    end
  end

  // ---- multiply stage
  logic signed [63:0] b_fm_q;
  logic signed [48:0] b_vdt_q;
  logic signed [62:0] b_ah_q;
  logic               b_is_y_q;
  logic               b_skip_q;
  logic signed [31:0] b_pos_q, b_vel_q, b_alast_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_MUL]) begin
      b_fm_q    <= item_i.force_req * item_i.inverse_mass;
      b_vdt_q   <= item_i.velocity * $signed({1'b0, time_step_i});
      b_ah_q    <= item_i.last_accel * $signed({1'b0, hdt2_q});
      b_is_y_q  <= (item_i.axis == AXIS_Y);
      b_skip_q  <= (item_i.inverse_mass <= 32'sd0);
      b_pos_q   <= item_i.position;
      b_vel_q   <= item_i.velocity;
      b_alast_q <= item_i.last_accel;
    end
  end

  // ---- acceleration: round, subtract gravity on y, clip
  logic signed [63:0]          fm_t;
  logic signed [63-FRAC_BITS:0] fm_rnd;
  logic signed [63:0]          anew_w;
  sat_t                        anew_s;

  assign fm_t   = b_fm_q + FM_HALF;
  assign fm_rnd = $signed(fm_t[63:FRAC_BITS]);
  assign anew_w = 64'(fm_rnd) - (b_is_y_q ? $signed({33'b0, gravity_i}) : 64'sd0);
  assign anew_s = sat32(anew_w);

  // ---- position: pos + v*dt + a*dt^2/2, each term rounded
  logic signed [48:0] vdt_t;
  logic signed [32:0] vdt_rnd;
  logic signed [62:0] ah_t;
  logic signed [30:0] ah_rnd;
  logic signed [63:0] pos_w;
  sat_t               pos_s;

  assign vdt_t   = b_vdt_q + 49'sd32768;
  assign vdt_rnd = $signed(vdt_t[48:16]);
  assign ah_t    = b_ah_q + 63'sd2147483648;
  assign ah_rnd  = $signed(ah_t[62:32]);
  assign pos_w   = 64'(b_pos_q) + 64'(vdt_rnd) + 64'(ah_rnd);
  assign pos_s   = sat32(pos_w);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_APOS]) begin
      ap_o.skip         <= b_skip_q;
      ap_o.clip         <= anew_s.clip | pos_s.clip;
      ap_o.position     <= b_pos_q;
      ap_o.velocity     <= b_vel_q;
      ap_o.last_accel   <= b_alast_q;
      ap_o.new_accel    <= $signed(anew_s.val);
      ap_o.new_position <= $signed(pos_s.val);
    end
  end

endmodule

>>> hdl/vvps_velocity.sv
// ============================================================================
// vvps_velocity
// Averaged-acceleration velocity update, damping and result assembly.
// ============================================================================
module vvps_velocity import vvps_pkg::*; (
  input  logic              clk_i,
  input  pipe_ctl_t         ctl_i,
  input  ap_item_t          ap_i,
  input  logic [TS_W-1:0]   time_step_i,
  input  logic [DAMP_W-1:0] damping_i,
  output res_t              res_o
);

  // ---- (alast + anew) * dt
  logic signed [32:0] asum;
  logic signed [49:0] d_prod_q;
  ap_item_t           d_q;

  assign asum = 33'(ap_i.last_accel) + 33'(ap_i.new_accel);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_ASUM]) begin
      d_prod_q <= asum * $signed({1'b0, time_step_i});
      d_q      <= ap_i;
    end
  end

  // ---- vel + round(prod / 2^17)
  logic signed [49:0] d_t;
  logic signed [32:0] d_rnd;
  logic signed [34:0] e_v1_q;
  ap_item_t           e_q;

  assign d_t   = d_prod_q + 50'sd65536;
  assign d_rnd = $signed(d_t[49:17]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_VSUM]) begin
      e_v1_q <= 35'(d_q.velocity) + 35'(d_rnd);
      e_q    <= d_q;
    end
  end

  // ---- times frame damping
  logic signed [52:0] f_prod_q;
  ap_item_t           f_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_DAMP]) begin
      f_prod_q <= e_v1_q * $signed({1'b0, damping_i});
      f_q      <= e_q;
    end
  end

  // ---- round, clip and select pass-through for immovable particles
  logic signed [52:0] f_t;
  logic signed [36:0] v_rnd;
  sat_t               v_s;
  res_t               res_d;

  assign f_t   = f_prod_q + 53'sd32768;
  assign v_rnd = $signed(f_t[52:16]);
  assign v_s   = sat32(64'(v_rnd));

  always_comb begin
    if (f_q.skip) begin
      res_d.skipped      = 1'b1;
      res_d.saturated    = 1'b0;
      res_d.new_position = f_q.position;
      res_d.new_velocity = f_q.velocity;
      res_d.new_accel    = f_q.last_accel;
    end else begin
      res_d.skipped      = 1'b0;
      res_d.saturated    = f_q.clip | v_s.clip;
      res_d.new_position = f_q.new_position;
      res_d.new_velocity = v_s.val;
      res_d.new_accel    = f_q.new_accel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_OUT]) begin
      res_o <= res_d;
    end
  end

endmodule

>>> hdl/velocity_verlet_particle_step_unit.sv
// ============================================================================
// velocity_verlet_particle_step_unit
// One velocity Verlet step for one axis of one particle, Q16.16 fixed point.
// ============================================================================
// Usage:
//   Slave stream carries one particle axis per transaction; the master stream
//   returns one result per transaction in the same order. The config channel
//   writes time step, frame damping and gravity and is always ready; write it
//   only while no transactions are in flight.
//   Pipeline: seven register stages, in order input, multiply, acceleration
//   and position, acceleration sum, velocity sum, damping and output.
//   Throughput: one transaction per clock while the master stream accepts
//   results; a new transaction enters before earlier ones have left.
//   Stall: each stage holds while the next is full and blocked, so a stalled
//   master backs up stage by stage; empty stages still fill, and s_axis_tready
//   drops only when every stage is occupied.
//   Reset: clears all stage valid bits and loads the default time step,
//   damping and gravity.
// ============================================================================
module velocity_verlet_particle_step_unit import vvps_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // position, velocity, last_accel, force_req, inverse_mass (32 bits each)
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // axis
  input  logic [1:0]           s_axis_tuser,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // new_position, new_velocity, new_accel (32 bits each)
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // skipped, saturated
  output logic [1:0]           m_axis_tuser,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  pipe_ctl_t ctl;
  item_t     item_q;
  ap_item_t  ap;
  res_t      res;

  logic [TS_W-1:0]   time_step_q;
  logic [DAMP_W-1:0] damping_q;
  logic [GRAV_W-1:0] gravity_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
      damping_q   <= DAMPING_RST;
      gravity_q   <= GRAVITY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TIME_STEP:     time_step_q <= cfg_data_i[TS_W-1:0];
        REG_FRAME_DAMPING: damping_q   <= cfg_data_i[DAMP_W-1:0];
        REG_GRAVITY:       gravity_q   <= cfg_data_i[GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  vvps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  // Input register
  always_ff @(posedge clk_i) begin
    if (ctl.load[ST_IN]) begin
      item_q.axis         <= s_axis_tuser;
      item_q.position     <= $signed(s_axis_tdata[31:0]);
      item_q.velocity     <= $signed(s_axis_tdata[63:32]);
      item_q.last_accel   <= $signed(s_axis_tdata[95:64]);
      item_q.force_req    <= $signed(s_axis_tdata[127:96]);
      item_q.inverse_mass <= $signed(s_axis_tdata[159:128]);
    end
  end

  vvps_accel_pos #(
    .FRAC_BITS (FRAC_BITS)
  ) u_accel_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .item_i      (item_q),
    .time_step_i (time_step_q),
    .gravity_i   (gravity_q),
    .ap_o        (ap)
  );

  vvps_velocity u_velocity (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .ap_i        (ap),
    .time_step_i (time_step_q),
    .damping_i   (damping_q),
    .res_o       (res)
  );

  // Output packing
  assign m_axis_tdata = {res.new_accel, res.new_velocity, res.new_position};
  assign m_axis_tuser = {res.saturated, res.skipped};

endmodule
